>>> sv/arch_pkg.sv
// ----------------------------------------------------------------------------
// arch_pkg: shared types and constants
// Command codes, sequencer states and fixed widths of the range hash table.
// ----------------------------------------------------------------------------
package arch_pkg;

   localparam int ADDR_W = 64;
   localparam int DIGIT_W = 16;
   localparam logic [63:0] FIB_MULT = 64'h9E37_79B9_7F4A_7C15;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_DEL   = 2'd1,
      CMD_FIND  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_HSTART,
      ST_HASH,
      ST_READ,
      ST_PROBE,
      ST_SH_READ,
      ST_SH_EVAL,
      ST_SH_HSTART,
      ST_SH_HASH,
      ST_SH_MOVE,
      ST_SH_CLR,
      ST_DONE
   } state_type;

endpackage

>>> sv/arch_if.sv
// ----------------------------------------------------------------------------
// arch_if: request and response channels
// Valid/ready channels carrying one command word and one result word.
// ----------------------------------------------------------------------------
interface arch_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [63:0] range_start;
   logic [63:0] range_end;
   logic        slab_kind;
   logic [63:0] lookup_addr;

   modport source (output valid, command, range_start, range_end, slab_kind, lookup_addr,
                   input ready);
   modport sink (input valid, command, range_start, range_end, slab_kind, lookup_addr,
                 output ready);
endinterface

interface arch_rsp_if #(parameter int USED_W = 13);
   logic              valid;
   logic              ready;
   logic              hit;
   logic              hit_slab;
   logic [63:0]       hit_start;
   logic [63:0]       hit_end;
   logic              table_full;
   logic [USED_W-1:0] entries_used;

   modport source (output valid, hit, hit_slab, hit_start, hit_end, table_full,
                   entries_used, input ready);
   modport sink (input valid, hit, hit_slab, hit_start, hit_end, table_full,
                 entries_used, output ready);
endinterface

>>> sv/address_range_chunk_hash.sv
// ----------------------------------------------------------------------------
// address_range_chunk_hash: open-addressing table of address ranges
// Linear-probe hash of 64 KiB chunks with backward-shift delete.
// ----------------------------------------------------------------------------
//  channel | direction | word
//  req_if  | in        | command, range_start, range_end, slab_kind, lookup_addr
//  rsp_if  | out       | hit, hit_slab, hit_start, hit_end, table_full, entries_used
//
//  Find hashes the lookup chunk and probes slots in turn. Add and delete
//  repeat that per covered chunk; delete also moves later entries back.
//  The cost is set by the iterative hash (one 16-bit digit a cycle) and the
//  registered slot memory read. Clear rewrites every slot of the table.
//  After reset a sweep of all TABLE_ENTRIES slots empties the memory; no word
//  is taken until it ends. A new word is taken while a result waits.
// ----------------------------------------------------------------------------
module address_range_chunk_hash
   import arch_pkg::*;
#(
   parameter int TABLE_ENTRIES = 4096,
   parameter int CHUNK_SHIFT = 16
) (
   input logic clock,
   input logic reset,
   arch_req_if.sink req_if,
   arch_rsp_if.source rsp_if
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int USED_W = IDX_W + 1;
   localparam int CHUNK_W = ADDR_W - CHUNK_SHIFT;
   localparam int DATA_W = 2 * ADDR_W + CHUNK_W + 1;
   localparam int LIMIT = TABLE_ENTRIES * 3 / 4;

   state_type state_ff, state_in;
   cmd_type cmd_ff;
   logic [ADDR_W-1:0]  s_ff, e_ff, a_ff;
   logic               k_ff;
   logic [CHUNK_W-1:0] p_ff, p_in, last_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in, hole_ff, hole_in;
   logic [DATA_W-1:0]  ent_ff;
   logic [USED_W-1:0]  used_ff, used_in;
   logic               full_ff, full_in;
   logic               clr_rsp_ff;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff;
   logic               rsp_hit_ff, rsp_slab_ff, rsp_full_ff;
   logic [ADDR_W-1:0]  rsp_start_ff, rsp_end_ff;
   logic [USED_W-1:0]  rsp_used_ff;
   logic               hit_slab_ff;
   logic [ADDR_W-1:0]  hit_start_ff, hit_end_ff;

   logic               accept, rsp_load;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr, mem_raddr;
   logic [DATA_W-1:0]  mem_wdata, rdata;
   logic               hash_start, hash_done;
   logic [CHUNK_W-1:0] hash_key;
   logic [IDX_W-1:0]   hash_home;

   logic [ADDR_W-1:0]  r_start, r_end;
   logic [CHUNK_W-1:0] r_chunk;
   logic               r_slab;
   logic               empty, same, found, last_chunk, between;
   logic               range_ok;
   logic [ADDR_W-1:0]  need, total;
   logic [IDX_W-1:0]   idx_next;

   assign r_start = rdata[ADDR_W-1:0];
   assign r_end   = rdata[2*ADDR_W-1:ADDR_W];
   assign r_chunk = rdata[2*ADDR_W +: CHUNK_W];
   assign r_slab  = rdata[DATA_W-1];

   assign empty = (r_start == '0);
   assign same = (r_chunk == p_ff) && (r_start == s_ff) && (r_end == e_ff) &&
                 (r_slab == k_ff);
   assign found = (r_chunk == p_ff) && (a_ff >= r_start) && (a_ff < r_end);
   assign last_chunk = (p_ff == last_ff);
   assign idx_next = idx_ff + 1'b1;
   assign range_ok = (e_ff > s_ff);
   assign need = ADDR_W'(last_ff) - ADDR_W'(p_ff) + 64'd1;
   assign total = ADDR_W'(used_ff) + need;

   always_comb begin
      if (hole_ff <= idx_ff) begin
         between = (hash_home > hole_ff) && (hash_home <= idx_ff);
      end else begin
         between = (hash_home > hole_ff) || (hash_home <= idx_ff);
      end
   end

   assign accept = req_if.valid && req_if.ready;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            unique case (cmd_ff)
               CMD_ADD: begin
                  state_in = (range_ok && s_ff != '0 && !full_ff &&
                              total < ADDR_W'(LIMIT)) ? ST_HSTART : ST_DONE;
               end
               CMD_DEL: begin
                  state_in = (range_ok && need < ADDR_W'(LIMIT)) ? ST_HSTART : ST_DONE;
               end
               CMD_FIND: state_in = ST_HSTART;
               CMD_CLEAR: state_in = ST_CLEAR;
            endcase
         end
         ST_HSTART: state_in = ST_HASH;
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_PROBE;
         ST_PROBE: begin
            priority if (cmd_ff == CMD_FIND) begin
               state_in = (empty || found) ? ST_DONE : ST_READ;
            end else if (cmd_ff == CMD_DEL && !empty && same) begin
               state_in = ST_SH_READ;
            end else if (empty || same) begin
               state_in = last_chunk ? ST_DONE : ST_HSTART;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SH_READ: state_in = ST_SH_EVAL;
         ST_SH_EVAL: begin
            if (empty) begin
               state_in = last_chunk ? ST_DONE : ST_HSTART;
            end else begin
               state_in = ST_SH_HSTART;
            end
         end
         ST_SH_HSTART: state_in = ST_SH_HASH;
         ST_SH_HASH: begin
            if (hash_done) begin
               state_in = between ? ST_SH_READ : ST_SH_MOVE;
            end
         end
         ST_SH_MOVE: state_in = ST_SH_CLR;
         ST_SH_CLR: state_in = ST_SH_READ;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      mem_we = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = '0;
      mem_raddr = idx_ff;
      hash_start = (state_ff == ST_HSTART) || (state_ff == ST_SH_HSTART);
      hash_key = (state_ff == ST_SH_HSTART) ? ent_ff[2*ADDR_W +: CHUNK_W] : p_ff;
      idx_in = idx_ff;
      hole_in = hole_ff;
      p_in = p_ff;
      used_in = used_ff;
      full_in = full_ff;
      hit_in = hit_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            idx_in = idx_next;
         end
         ST_CHECK: begin
            priority if (cmd_ff == CMD_CLEAR) begin
               idx_in = '0;
               used_in = '0;
               full_in = 1'b0;
            end else if (cmd_ff == CMD_ADD && range_ok && s_ff != '0 &&
                         (full_ff || total >= ADDR_W'(LIMIT))) begin
               full_in = 1'b1;
            end else begin
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               idx_in = hash_home;
            end
         end
         ST_PROBE: begin
            priority if (cmd_ff == CMD_FIND) begin
               if (!empty && found) begin
                  hit_in = 1'b1;
               end
               idx_in = idx_next;
            end else if (cmd_ff == CMD_DEL && !empty && same) begin
               mem_we = 1'b1;
               used_in = used_ff - 1'b1;
               hole_in = idx_ff;
               idx_in = idx_next;
            end else if (empty || same) begin
               if (cmd_ff == CMD_ADD && empty) begin
                  mem_we = 1'b1;
                  mem_wdata = {k_ff, p_ff, e_ff, s_ff};
                  used_in = used_ff + 1'b1;
               end
               p_in = p_ff + 1'b1;
            end else begin
               idx_in = idx_next;
            end
         end
         ST_SH_EVAL: begin
            if (empty) begin
               p_in = p_ff + 1'b1;
            end
         end
         ST_SH_HASH: begin
            if (hash_done && between) begin
               idx_in = idx_next;
            end
         end
         ST_SH_MOVE: begin
            mem_we = 1'b1;
            mem_waddr = hole_ff;
            mem_wdata = ent_ff;
         end
         ST_SH_CLR: begin
            mem_we = 1'b1;
            hole_in = idx_ff;
            idx_in = idx_next;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff <= '0;
         used_ff <= '0;
         full_ff <= 1'b0;
         clr_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         used_ff <= used_in;
         full_ff <= full_in;
         if (state_ff == ST_CHECK) begin
            clr_rsp_ff <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      hole_ff <= hole_in;
      if (accept) begin
         cmd_ff <= cmd_type'(req_if.command);
         s_ff <= req_if.range_start;
         e_ff <= req_if.range_end;
         k_ff <= req_if.slab_kind;
         a_ff <= req_if.lookup_addr;
         last_ff <= CHUNK_W'((req_if.range_end - 64'd1) >> CHUNK_SHIFT);
         hit_ff <= 1'b0;
         if (cmd_type'(req_if.command) == CMD_FIND) begin
            p_ff <= CHUNK_W'(req_if.lookup_addr >> CHUNK_SHIFT);
         end else begin
            p_ff <= CHUNK_W'(req_if.range_start >> CHUNK_SHIFT);
         end
      end else begin
         p_ff <= p_in;
         hit_ff <= hit_in;
      end
      if (state_ff == ST_SH_EVAL) begin
         ent_ff <= rdata;
      end
      if (state_ff == ST_PROBE && cmd_ff == CMD_FIND && !empty && found) begin
         hit_slab_ff <= r_slab;
         hit_start_ff <= r_start;
         hit_end_ff <= r_end;
      end
      if (rsp_load) begin
         rsp_hit_ff <= hit_ff;
         rsp_slab_ff <= hit_ff & hit_slab_ff;
         rsp_start_ff <= hit_ff ? hit_start_ff : '0;
         rsp_end_ff <= hit_ff ? hit_end_ff : '0;
         rsp_full_ff <= full_ff;
         rsp_used_ff <= used_ff;
      end
   end

   arch_hash #(
      .KEY_W (CHUNK_W),
      .IDX_W (IDX_W)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (hash_key),
      .done  (hash_done),
      .home  (hash_home)
   );

   arch_mem #(
      .DEPTH  (TABLE_ENTRIES),
      .ADDR_W (IDX_W),
      .DATA_W (DATA_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (rdata)
   );

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.hit = rsp_hit_ff;
   assign rsp_if.hit_slab = rsp_slab_ff;
   assign rsp_if.hit_start = rsp_start_ff;
   assign rsp_if.hit_end = rsp_end_ff;
   assign rsp_if.table_full = rsp_full_ff;
   assign rsp_if.entries_used = rsp_used_ff;

   a_used_limit: assert property (@(posedge clock) disable iff (reset)
      used_ff < USED_W'(LIMIT))
      else $error("occupancy passed the load limit");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_we)
      else $error("slot write while idle");

   a_hash_owner: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> state_ff == ST_HASH || state_ff == ST_SH_HASH)
      else $error("hash result with no waiting probe");

   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      $fell(full_ff) |-> $past(cmd_ff) == CMD_CLEAR)
      else $error("full flag dropped without clear");

endmodule

>>> sv/arch_hash.sv
// ----------------------------------------------------------------------------
// arch_hash: Fibonacci home-slot hash
// Multiplies the chunk by the golden-ratio constant one 16-bit digit per
// cycle and returns the top index bits of the 64-bit product.
// ----------------------------------------------------------------------------
module arch_hash
   import arch_pkg::*;
#(
   parameter int KEY_W = 48,
   parameter int IDX_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output logic             done,
   output logic [IDX_W-1:0] home
);

   localparam int NDIG = (KEY_W + DIGIT_W - 1) / DIGIT_W;
   localparam int PAD_W = NDIG * DIGIT_W;
   localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

   logic [PAD_W-1:0] key_ff;
   logic [63:0]      acc_ff;
   logic [63:0]      mult_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [63:0]      prod;

   assign prod = {{(64-DIGIT_W){1'b0}}, key_ff[DIGIT_W-1:0]} * mult_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(NDIG - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         key_ff  <= PAD_W'(key);
         acc_ff  <= '0;
         mult_ff <= FIB_MULT;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         key_ff  <= key_ff >> DIGIT_W;
         acc_ff  <= acc_ff + prod;
         mult_ff <= mult_ff << DIGIT_W;
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   assign done = done_ff;
   assign home = acc_ff[63 -: IDX_W];

endmodule

>>> sv/arch_mem.sv
// ----------------------------------------------------------------------------
// arch_mem: slot store
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
module arch_mem #(
   parameter int DEPTH = 4096,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 177
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
